/* rtl/fwir_pkg.sv */
// ============================================================================
// fwir_pkg: shared types and constants for the indexed-removal FIFO
// Defines the command and result words, the operation and error codes and
// the per-cell control group.
// ============================================================================
`default_nettype none

package fwir_pkg;

    localparam int DATA_W  = 32;
    localparam int MODE_W  = 2;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;
    localparam int ERR_W   = 2;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_RANGE = 2'd2,
        ERR_FULL  = 2'd3
    } t_err;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] head_value;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
        t_err                     error_code;
    } t_res;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/fifo_with_indexed_removal_unit.sv */
// ============================================================================
// fifo_with_indexed_removal_unit: FIFO with append, pop and remove-at-index
// A row of storage cells, cell 0 at the head; removals shift the upper cells
// down one place.
// ============================================================================
// Output: the result word appears on o_res with o_strobe in the cycle
//   after the command word is taken (start high while busy is low).
// Throughput: one command word per cycle; busy stays low, since every cell
//   updates in the same cycle the command is taken.
// Reset: the element count and the result strobe clear; cell contents are
//   left as they are and are never read before being written.
`default_nettype none

module fifo_with_indexed_removal_unit
    import fwir_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_cmd i_cmd,
    output logic      o_strobe,
    output t_res      o_res
);

    // Count width holds DEPTH itself; the compare width also covers the
    // four-bit position field.
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_strobe;
    t_res          r_res;
    t_res          n_res;

    logic          w_append;
    logic          w_remove;
    logic [PW-1:0] w_idx;
    t_err          w_err;
    logic [PW-1:0] w_pos_ext;
    logic [PW-1:0] w_cnt_ext;
    logic          w_empty;
    logic          w_full;

    t_cell_ctl                w_ctl  [DEPTH];
    logic [DEPTH-1:0]         w_load;
    logic signed [DATA_W-1:0] w_data [DEPTH];
    logic signed [DATA_W-1:0] w_next [DEPTH];

    // The block never holds off a command word, so busy is tied low.
    assign busy = 1'b0;

    assign w_pos_ext = PW'(i_cmd.position);
    assign w_cnt_ext = PW'(r_count);
    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count == CW'(DEPTH));

    // Decode the command. A failing operation sets the error code and
    // leaves every cell and the count untouched.
    always_comb begin
        w_append = 1'b0;
        w_remove = 1'b0;
        w_idx    = '0;
        w_err    = ERR_OK;
        if (start) begin
            case (i_cmd.mode)
                MODE_APPEND: begin
                    if (w_full) begin
                        w_err = ERR_FULL;
                    end else begin
                        w_append = 1'b1;
                    end
                end
                MODE_POP: begin
                    if (w_empty) begin
                        w_err = ERR_EMPTY;
                    end else begin
                        w_remove = 1'b1;
                    end
                end
                MODE_REMOVE: begin
                    if (w_empty) begin
                        w_err = ERR_EMPTY;
                    end else if (w_pos_ext >= w_cnt_ext) begin
                        w_err = ERR_RANGE;
                    end else begin
                        w_remove = 1'b1;
                        w_idx    = w_pos_ext;
                    end
                end
                default: begin
                    // The unused mode code reports the queue as it stands.
                end
            endcase
        end
    end

    // Per-cell control: an append loads the cell just past the tail; a
    // removal makes every occupied cell from the index upward take its
    // neighbor's element, except the old tail cell, which simply drops out.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_ctl[i].load  = w_append && (CW'(i) == r_count);
            w_ctl[i].shift = w_remove && (PW'(i) >= w_idx) && (PW'(i + 1) < w_cnt_ext);
            w_load[i]      = w_ctl[i].load;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [DATA_W-1:0] w_nb;
            if (g == DEPTH - 1) begin : g_last
                assign w_nb = '0;
            end else begin : g_mid
                assign w_nb = w_data[g + 1];
            end
            fwir_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[g]),
                .i_value    (i_cmd.value),
                .i_neighbor (w_nb),
                .o_data     (w_data[g]),
                .o_next     (w_next[g])
            );
        end
    endgenerate

    // Next count and the result word, both taken from the state as it
    // will be after this operation.
    always_comb begin
        n_count = r_count;
        if (w_append) begin
            n_count = r_count + CW'(1);
        end else if (w_remove) begin
            n_count = r_count - CW'(1);
        end
        n_res.head_value = (n_count == '0) ? '0 : w_next[0];
        n_res.count      = COUNT_W'(n_count);
        n_res.is_empty   = (n_count == '0);
        n_res.error_code = w_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= start;
        end
    end

    // The result word itself needs no reset; the strobe qualifies it.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // Every accepted command yields exactly one strobe in the next cycle.
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> o_strobe)
        else $error("command word without a result word");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |=> !o_strobe)
        else $error("result word without a command word");

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond capacity");

    // A failing operation leaves the count unchanged.
    a_fail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && (w_err != ERR_OK) |=> r_count == $past(r_count))
        else $error("failed operation changed the queue");

    // At most one cell loads per cycle.
    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_load))
        else $error("more than one cell loaded");

    // The empty flag agrees with the stored count.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_res.is_empty == (r_count == '0)))
        else $error("empty flag disagrees with count");

endmodule

`default_nettype wire

/* rtl/fwir_cell.sv */
// ============================================================================
// fwir_cell: one storage cell of the queue
// Holds one element; loads a new element or takes its upper neighbor's
// element when the queue closes a gap.
// ============================================================================
`default_nettype none

module fwir_cell
    import fwir_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_cell_ctl                i_ctl,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic signed [DATA_W-1:0] i_neighbor,
    output logic signed [DATA_W-1:0]      o_data,
    output logic signed [DATA_W-1:0]      o_next
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift) begin
            n_data = i_neighbor;
        end else if (i_ctl.load) begin
            n_data = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_next = n_data;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ============================================================================
// testbench: self-checking bench for fifo_with_indexed_removal_unit
// Directed words from a table, then random append/pop/remove traffic shaped
// in bursts that fill and drain the queue. A local queue model predicts each
// result word, and every strobed result is compared field by field.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
    import fwir_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    // The package leaves the fourth mode code unnamed. The block treats it as a
    // no-op that just reports the current queue.
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int RANDOM_WORDS = 750;
    localparam int CYCLE_LIMIT  = 50000;
    localparam int REPORT_CAP   = 100;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_cmd i_cmd;
    logic o_strobe;
    t_res o_res;

    fifo_with_indexed_removal_unit #(.DEPTH(DEPTH)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Queue model. It holds the elements in order with the head in cell 0,
    // the same way the block's row of cells does.
    // ------------------------------------------------------------------------
    logic signed [DATA_W-1:0] model_cells [DEPTH];
    int                       model_len = 0;

    t_res pending_results [$];
    int   mismatches  = 0;
    int   taken_words = 0;
    int   cycles      = 0;

    // The driver may attach a hand-written expectation to the word it drives.
    // When it does, that expectation replaces the model's, although the model
    // still steps so that its state follows the block.
    bit   typed_valid = 1'b0;
    t_res typed_res;
    bit   idle_on = 1'b0;

    // Applies one command word to the model and returns the result word that
    // the block should report. A failing command leaves the model untouched.
    task automatic apply_queue_op(input t_cmd c, output t_res r);
        t_err err;
        int   gap;
        int   k;
        err = ERR_OK;
        gap = -1;
        case (c.mode)
            MODE_APPEND: begin
                if (model_len >= DEPTH) begin
                    err = ERR_FULL;
                end else begin
                    model_cells[model_len] = c.value;
                    model_len++;
                end
            end
            MODE_POP: begin
                if (model_len == 0) err = ERR_EMPTY;
                else gap = 0;
            end
            MODE_REMOVE: begin
                if (model_len == 0) err = ERR_EMPTY;
                else if (int'(c.position) >= model_len) err = ERR_RANGE;
                else gap = int'(c.position);
            end
            default: begin
            end
        endcase
        // Removal closes the gap by moving every later element down one place.
        if (gap >= 0) begin
            for (k = gap; k + 1 < model_len; k++) model_cells[k] = model_cells[k + 1];
            model_len--;
        end
        r.head_value = (model_len > 0) ? model_cells[0] : '0;
        r.count      = COUNT_W'(model_len);
        r.is_empty   = (model_len == 0);
        r.error_code = err;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < REPORT_CAP)
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor. It samples at the rising edge, where the inputs, which move on
    // the falling edge, are stable. A result word on the strobe belongs to an
    // earlier command, so it is checked before this edge's command is
    // predicted.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else if (i_rst_n) begin
            if (o_strobe) begin
                got = o_res;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result word", 32'(got), '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.head_value !== want.head_value)
                        report_mismatch("head_value", got.head_value, want.head_value);
                    if (got.count !== want.count)
                        report_mismatch("count", 32'(got.count), 32'(want.count));
                    if (got.is_empty !== want.is_empty)
                        report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
                    if (got.error_code !== want.error_code)
                        report_mismatch("error_code", 32'(got.error_code),
                                        32'(want.error_code));
                end
            end
            if (start && !busy) begin
                apply_queue_op(i_cmd, want);
                pending_results.push_back(typed_valid ? typed_res : want);
                taken_words++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver. Each word is presented at a falling edge and held until the
    // monitor has counted it as taken. Idle cycles are drawn before a word
    // when idling is on. Every assignment to start is followed by a clock
    // wait, so start never gets two updates in one time step.
    // ------------------------------------------------------------------------
    task automatic send_word(input t_cmd c, input bit has_exp, input t_res exp_res);
        int seen;
        while (idle_on && $urandom_range(0, 99) < 13) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_cmd       <= c;
        typed_valid = has_exp;
        typed_res   = exp_res;
        start       <= 1'b1;
        seen        = taken_words;
        do @(negedge i_clk); while (taken_words == seen);
    endtask

    // Stops sending and waits until every expected result word has come back.
    task automatic hold_until_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    // Draws one random command word. bias is the chance, in percent, of an
    // append, so a burst either fills, drains or churns the queue. Most
    // removals pick a position that is in range for the current queue.
    task automatic draw_random_word(input int bias, output t_cmd c);
        int pick;
        c.value = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < bias) begin
            c.mode = MODE_APPEND;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 35) c.mode = MODE_POP;
            else if (pick < 95) c.mode = MODE_REMOVE;
            else c.mode = MODE_NONE;
        end
        if (model_len > 0 && $urandom_range(0, 99) < 85)
            c.position = POS_W'($urandom_range(0, model_len - 1));
        else
            c.position = POS_W'($urandom_range(0, 15));
    endtask

    // ------------------------------------------------------------------------
    // Directed table. A row may repeat; a repeated row adds its repeat index
    // to the value, which fills the queue with distinct elements.
    // ------------------------------------------------------------------------
    typedef struct {
        t_cmd cmd;
        int   reps;
        bit   has_exp;
        t_res exp_res;
    } t_row;

    t_row plan [$];

    function automatic void add_row(input logic [MODE_W-1:0] mode,
                                    input logic [DATA_W-1:0] value,
                                    input logic [POS_W-1:0] position, input int reps,
                                    input bit has_exp, input logic [DATA_W-1:0] head,
                                    input int count, input bit empty, input t_err err);
        t_row row;
        row.cmd.mode              = mode;
        row.cmd.value             = value;
        row.cmd.position          = position;
        row.reps                  = reps;
        row.has_exp               = has_exp;
        row.exp_res.head_value    = head;
        row.exp_res.count         = COUNT_W'(count);
        row.exp_res.is_empty      = empty;
        row.exp_res.error_code    = err;
        plan.push_back(row);
    endfunction

    initial begin
        t_cmd c;
        int   bias;
        int   n;
        int   r;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;

        // Removals and the no-op on the empty queue after reset.
        add_row(MODE_POP,    32'h0,        4'd0,  1, 1, 32'h0, 0, 1, ERR_EMPTY);
        add_row(MODE_REMOVE, 32'hFFFFFFFF, 4'd15, 1, 1, 32'h0, 0, 1, ERR_EMPTY);
        add_row(MODE_NONE,   32'h0,        4'd0,  1, 1, 32'h0, 0, 1, ERR_OK);
        // Extreme values, a position just past the count, then empty again.
        add_row(MODE_APPEND, 32'h7FFFFFFF, 4'd0,  1, 1, 32'h7FFFFFFF, 1, 0, ERR_OK);
        add_row(MODE_APPEND, 32'h80000000, 4'd15, 1, 1, 32'h7FFFFFFF, 2, 0, ERR_OK);
        add_row(MODE_REMOVE, 32'h0,        4'd2,  1, 1, 32'h7FFFFFFF, 2, 0, ERR_RANGE);
        add_row(MODE_REMOVE, 32'h0,        4'd1,  1, 1, 32'h7FFFFFFF, 1, 0, ERR_OK);
        add_row(MODE_POP,    32'h0,        4'd0,  1, 1, 32'h0, 0, 1, ERR_OK);
        // Fill to the top, then append once more to a full queue.
        add_row(MODE_APPEND, 32'h5A5A0000, 4'd0,  DEPTH, 0, 32'h0, 0, 0, ERR_OK);
        add_row(MODE_APPEND, 32'h00000001, 4'd0,  1, 1, 32'h5A5A0000, DEPTH, 0, ERR_FULL);
        // The rest work on a full or nearly full queue and go to the model.
        add_row(MODE_NONE,   32'h0,        4'd0,  1, 0, 32'h0, 0, 0, ERR_OK);
        add_row(MODE_REMOVE, 32'h0,        4'd15, 1, 0, 32'h0, 0, 0, ERR_OK);
        add_row(MODE_REMOVE, 32'h0,        4'd0,  1, 0, 32'h0, 0, 0, ERR_OK);
        add_row(MODE_POP,    32'h0,        4'd0,  1, 0, 32'h0, 0, 0, ERR_OK);
        add_row(MODE_REMOVE, 32'h0,        4'd14, 1, 0, 32'h0, 0, 0, ERR_OK);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            for (r = 0; r < plan[i].reps; r++) begin
                c = plan[i].cmd;
                c.value = c.value + r;
                send_word(c, plan[i].has_exp, plan[i].exp_res);
            end
        end
        hold_until_drained();

        // Random part. The bias changes every 40 words, and one stretch runs
        // with no idle cycles at all so that words arrive back to back.
        idle_on = 1'b1;
        bias = 50;
        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 40 == 0) begin
                r = $urandom_range(0, 2);
                bias = (r == 0) ? 80 : (r == 1) ? 50 : 25;
            end
            idle_on = !(n >= 250 && n < 400);
            if (n == 500) hold_until_drained();
            draw_random_word(bias, c);
            send_word(c, 1'b0, '0);
        end

        hold_until_drained();
        repeat (4) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/fwir_pkg.sv
rtl/fwir_cell.sv
rtl/fifo_with_indexed_removal_unit.sv
tb/testbench.sv
